[design/sacache_pkg.sv]
// Shared types, constants and helpers for the set-associative cache simulator.
// Used by sacache_store, sacache_engine and set_assoc_cache_lru_sim; no dependencies.
package sacache_pkg;

   // Geometry
   localparam int MAX_SETS     = 64;
   localparam int WAYS         = 8;
   localparam int ADDR_W       = 64;
   localparam int TAG_W        = ADDR_W;
   localparam int CNT_W        = 32;

   // Largest usable set-bit count: largest n with 2^n <= MAX_SETS
   localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_W        = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
   localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCNT_W       = $clog2(WAYS + 1);

   // Config register widths
   localparam int SB_W         = 3;
   localparam int BB_W         = 6;
   localparam int WU_W         = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;

   // Config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd2;

   // Commands
   localparam logic [1:0] CMD_MODIFY = 2'd2;

   // Outcome codes
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   // One set: LRU order (entry 0 least recent), valid flags, tags
   typedef struct packed {
      logic [WAYS-1:0][WAY_W-1:0] lru;
      logic [WAYS-1:0]            valid;
      logic [WAYS-1:0][TAG_W-1:0] tags;
   } row_type;

   // Decoded access
   typedef struct packed {
      logic [SET_W-1:0]  set;
      logic [TAG_W-1:0]  tag;
      logic [WCNT_W-1:0] nways;
      logic              twice;
   } access_type;

   // Store port
   typedef struct packed {
      logic             rd;
      logic             wr;
      logic [SET_W-1:0] set;
      row_type          wdata;
   } store_req_type;

   // Row contents after reset or config write
   function automatic row_type reset_row();
      row_type r;
      r.valid = '0;
      r.tags  = '0;
      for (int w = 0; w < WAYS; w++) begin
         r.lru[w] = WAY_W'(w);
      end
      return r;
   endfunction

   // Saturating increment
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

[design/set_assoc_cache_lru_sim.sv]
// Set-associative cache simulator with LRU replacement: top level.
// Holds config registers and address decode; instantiates sacache_store and sacache_engine.
//
//   channel  ports            content
//   req      req_t*           tdata address, tuser cmd
//   rsp      rsp_t*           tdata outcome and counts, tlast final result of a request
//   csr      csr_*            register index and write data
//
// A load or store passes through accept, RAM read, tag match, and update and write-back;
// a modify repeats read, match and update, its second access re-reading the written set.
// Each access reads then writes one row of the single-port set RAM.
// Reset and any write to a config register clear all sets at once through per-row valid flops; no sweep.
// A waiting response stalls only the next update; a new request is taken while it waits.
module set_assoc_cache_lru_sim (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sacache_pkg::ADDR_W-1:0]     req_tdata,   // [63:0] address
   input  logic [1:0]                         req_tuser,   // [1:0] cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] outcome, [33:2] hit_total, [65:34] miss_total, [97:66] evict_total, rest zero
   output logic [103:0]                       rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sacache_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sacache_pkg::CSR_DATA_W-1:0] csr_data
);
   import sacache_pkg::*;

   localparam int SH_W = 7;

   logic [SB_W-1:0]   set_bits_ff, set_bits_in;
   logic [BB_W-1:0]   block_bits_ff, block_bits_in;
   logic [WU_W-1:0]   ways_used_ff, ways_used_in;
   logic              clear;
   logic              csr_fire;

   logic [SB_W-1:0]   sb;
   logic [ADDR_W-1:0] shifted;
   logic [SH_W-1:0]   tag_shift;
   access_type        acc;
   logic              req_fire;

   store_req_type     st_req;
   row_type           st_row;
   logic              rsp_valid;
   logic [1:0]        rsp_outcome;
   logic              rsp_last;
   logic [CNT_W-1:0]  hit_total, miss_total, evict_total;

   // Config registers; a write to a listed register clears the cache
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_used_in  = ways_used_ff;
      clear         = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_SET_BITS: begin
               set_bits_in = csr_data[SB_W-1:0];
               clear       = 1'b1;
            end
            CSR_BLOCK_BITS: begin
               block_bits_in = csr_data[BB_W-1:0];
               clear         = 1'b1;
            end
            CSR_WAYS_USED: begin
               ways_used_in = csr_data[WU_W-1:0];
               clear        = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SB_W'(4);
         block_bits_ff <= BB_W'(4);
         ways_used_ff  <= WU_W'(1);
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_used_ff  <= ways_used_in;
      end
   end

   // Address decode; set bits are capped so the set index always stays below MAX_SETS
   always_comb begin
      sb        = (set_bits_ff > SB_W'(SET_BITS_MAX)) ? SB_W'(SET_BITS_MAX) : set_bits_ff;
      shifted   = req_tdata >> block_bits_ff;
      tag_shift = SH_W'(sb) + SH_W'(block_bits_ff);
      acc.set   = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
      acc.tag   = (tag_shift < SH_W'(ADDR_W)) ? (req_tdata >> tag_shift) : '0;
      if (ways_used_ff == '0) begin
         acc.nways = WCNT_W'(1);
      end else if (ways_used_ff > WU_W'(WAYS)) begin
         acc.nways = WCNT_W'(WAYS);
      end else begin
         acc.nways = WCNT_W'(ways_used_ff);
      end
      acc.twice = (req_tuser == CMD_MODIFY);
   end

   assign req_fire = req_tvalid && req_tready;

   sacache_store u_store (
      .clock  (clock),
      .reset  (reset),
      .clear  (clear),
      .st_req (st_req),
      .st_row (st_row)
   );

   sacache_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .acc_i       (acc),
      .req_fire    (req_fire),
      .ready       (req_tready),
      .st_req      (st_req),
      .st_row      (st_row),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_tready),
      .rsp_outcome (rsp_outcome),
      .rsp_last    (rsp_last),
      .hit_total   (hit_total),
      .miss_total  (miss_total),
      .evict_total (evict_total)
   );

   // Response packing
   assign rsp_tvalid = rsp_valid;
   assign rsp_tlast  = rsp_last;
   assign rsp_tdata  = {6'd0, evict_total, miss_total, hit_total, rsp_outcome};

   // Hit count never goes backward
   a_hit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_tdata[33:2] >= $past(rsp_tdata[33:2])))
      else $error("hit count decreased");

   // Every eviction is also a miss
   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tdata[97:66] <= rsp_tdata[65:34])
      else $error("eviction count exceeds miss count");

   // A reported hit or eviction is reflected in its count
   a_count_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[1:0] != OUT_HIT || rsp_tdata[33:2] != '0)
                      && (rsp_tdata[1:0] != OUT_EVICT || rsp_tdata[97:66] != '0)))
      else $error("outcome not reflected in counts");

endmodule

[design/sacache_store.sv]
// Set store: one row per set holding tags, valid flags and LRU order.
// Single-port synchronous RAM with registered read, plus per-row valid flops; uses sacache_pkg.
module sacache_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  sacache_pkg::store_req_type st_req,
   output sacache_pkg::row_type       st_row
);
   import sacache_pkg::*;

   row_type               mem [MAX_SETS];
   row_type               rd_data_ff;
   logic                  rd_ok_ff;
   logic [MAX_SETS-1:0]   row_ok_ff;
   logic [MAX_SETS-1:0]   row_ok_in;

   // RAM array
   always_ff @(posedge clock) begin
      if (st_req.wr) begin
         mem[st_req.set] <= st_req.wdata;
      end
      if (st_req.rd) begin
         rd_data_ff <= mem[st_req.set];
      end
   end

   // Row valid flags: a row never written since reset or clear reads as reset contents
   always_comb begin
      row_ok_in = row_ok_ff;
      if (st_req.wr) begin
         row_ok_in[st_req.set] = 1'b1;
      end
      if (clear) begin
         row_ok_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
         rd_ok_ff  <= 1'b0;
      end else begin
         row_ok_ff <= row_ok_in;
         if (st_req.rd) begin
            rd_ok_ff <= row_ok_ff[st_req.set];
         end
      end
   end

   assign st_row = rd_ok_ff ? rd_data_ff : reset_row();

endmodule

[design/sacache_engine.sv]
// Access sequencer: read set, match tags, update LRU and write back, count and respond.
// Drives sacache_store through store_req_type; uses sacache_pkg.
module sacache_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  sacache_pkg::access_type       acc_i,
   input  logic                          req_fire,
   output logic                          ready,
   output sacache_pkg::store_req_type    st_req,
   input  sacache_pkg::row_type          st_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_outcome,
   output logic                          rsp_last,
   output logic [sacache_pkg::CNT_W-1:0] hit_total,
   output logic [sacache_pkg::CNT_W-1:0] miss_total,
   output logic [sacache_pkg::CNT_W-1:0] evict_total
);
   import sacache_pkg::*;

   typedef enum logic [1:0] {IDLE, READ, MATCH, UPDATE} state_type;

   state_type         state_ff, state_in;
   access_type        acc_ff, acc_in;
   logic              second_ff, second_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic [1:0]        outcome_ff, outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_outcome_ff, rsp_outcome_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]  hit_ff, hit_in;
   logic [CNT_W-1:0]  miss_ff, miss_in;
   logic [CNT_W-1:0]  evict_ff, evict_in;

   logic [WAYS-1:0]   hit_vec, inv_vec;
   logic [WAY_W-1:0]  hit_way, inv_way;
   logic              seen;
   row_type           row_new;
   logic              upd_fire;

   // Tag match over the ways in use, lowest way first
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = (WCNT_W'(w) < acc_ff.nways) && st_row.valid[w]
                      && (st_row.tags[w] == acc_ff.tag);
         inv_vec[w] = (WCNT_W'(w) < acc_ff.nways) && !st_row.valid[w];
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = WAY_W'(w);
         if (inv_vec[w]) inv_way = WAY_W'(w);
      end
   end

   // Row update: tag and valid for the chosen way, chosen way moved to most recent
   always_comb begin
      row_new = st_row;
      row_new.tags[way_ff]  = acc_ff.tag;
      row_new.valid[way_ff] = 1'b1;
      seen = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if ((WCNT_W'(i) < acc_ff.nways) && (st_row.lru[i] == way_ff)) begin
            seen = 1'b1;
         end
         if (seen && (WCNT_W'(i) < acc_ff.nways)) begin
            if (WCNT_W'(i + 1) == acc_ff.nways) begin
               row_new.lru[i] = way_ff;
            end else if (i < WAYS - 1) begin
               row_new.lru[i] = st_row.lru[(i + 1) % WAYS];
            end
         end
      end
   end

   assign upd_fire = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      second_in      = second_ff;
      way_in         = way_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_last_in    = rsp_last_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      evict_in       = evict_ff;
      st_req.rd      = 1'b0;
      st_req.wr      = 1'b0;
      st_req.set     = acc_ff.set;
      st_req.wdata   = row_new;
      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               acc_in    = acc_i;
               second_in = 1'b0;
               state_in  = READ;
            end
         end
         READ: begin
            st_req.rd = 1'b1;
            state_in  = MATCH;
         end
         MATCH: begin
            if (|hit_vec) begin
               outcome_in = OUT_HIT;
               way_in     = hit_way;
            end else if (|inv_vec) begin
               outcome_in = OUT_FILL;
               way_in     = inv_way;
            end else begin
               outcome_in = OUT_EVICT;
               way_in     = st_row.lru[0];
            end
            state_in = UPDATE;
         end
         UPDATE: begin
            if (upd_fire) begin
               st_req.wr      = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_last_in    = !(acc_ff.twice && !second_ff);
               if (outcome_ff == OUT_HIT) begin
                  hit_in = sat_inc(hit_ff);
               end else begin
                  miss_in = sat_inc(miss_ff);
               end
               if (outcome_ff == OUT_EVICT) begin
                  evict_in = sat_inc(evict_ff);
               end
               if (acc_ff.twice && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = READ;
               end else begin
                  state_in  = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      second_ff      <= second_in;
      way_ff         <= way_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
      end
   end

   // Counters only move when a response is loaded, so they travel with it
   assign ready       = (state_ff == IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_last    = rsp_last_ff;
   assign hit_total   = hit_ff;
   assign miss_total  = miss_ff;
   assign evict_total = evict_ff;

endmodule
